// File: rtl/core/mjlr_pkg.sv
// Shared constants, types and arithmetic helpers of the multi-joint linear ramp.
package mjlr_pkg;

  localparam int JOINTS       = 7;
  localparam int MAX_COMMANDS = 8;
  localparam int POS_BITS     = 24;

  localparam int JIDX_W   = 3;
  localparam int TICK_W   = 10;
  localparam int MARGIN_W = 16;
  localparam int DUR_W    = 16;
  localparam int CNT_W    = $clog2(MAX_COMMANDS + 1);
  localparam int IDX_W    = $clog2(MAX_COMMANDS);

  // Serial divider: dividend holds a duration or a position magnitude, divisor a tick period or a tick count.
  localparam int DIV_N     = POS_BITS;
  localparam int DIV_D     = DUR_W;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TICK_W-1:0]   TICK_RESET   = TICK_W'(30);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(655);

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [POS_BITS+1:0] wide_t;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic {
    REG_TICK_PERIOD   = 1'b0,
    REG_ARRIVE_MARGIN = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_TICKS,
    ST_DIV_STEP,
    ST_STORE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FINISH,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic div_ticks;
    logic div_step;
    logic store;
    logic walk_a;
    logic walk_b;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  reject;
    logic  div_busy;
    logic  walk_more;
    logic  out_free;
  } ctl_sts_t;

  function automatic pos_t sat_pos(input wide_t v);
    wide_t vmax;
    wide_t vmin;
    vmax = {3'b000, {(POS_BITS-1){1'b1}}};
    vmin = {3'b111, {(POS_BITS-1){1'b0}}};
    if (v > vmax) return {1'b0, {(POS_BITS-1){1'b1}}};
    if (v < vmin) return {1'b1, {(POS_BITS-1){1'b0}}};
    return v[POS_BITS-1:0];
  endfunction

  // True while the joint is still further from its target than the margin,
  // looking in the direction of the step.
  function automatic logic short_of(input pos_t pos, input pos_t target, input pos_t step,
                                    input logic [MARGIN_W-1:0] mg);
    wide_t p;
    wide_t t;
    wide_t m;
    p = {{2{pos[POS_BITS-1]}}, pos};
    t = {{2{target[POS_BITS-1]}}, target};
    m = {{(POS_BITS+2-MARGIN_W){1'b0}}, mg};
    return (!step[POS_BITS-1] && (step != '0) && (p + m < t)) ||
           (step[POS_BITS-1] && (p - m > t));
  endfunction

endpackage

// File: rtl/core/mjlr_in_if.sv
// Input channel: command or tick word with valid/ready handshake.
interface mjlr_in_if;
  import mjlr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [JIDX_W-1:0] joint_index;
  pos_t              target_position;
  logic [DUR_W-1:0]  duration_ms;

  modport source (output valid, kind, joint_index, target_position, duration_ms,
                  input ready);
  modport sink   (input valid, kind, joint_index, target_position, duration_ms,
                  output ready);
endinterface

// File: rtl/core/mjlr_out_if.sv
// Output channel: joint positions and status flags with valid/ready handshake.
interface mjlr_out_if;
  import mjlr_pkg::*;

  logic valid;
  logic ready;
  pos_t joint0_position;
  pos_t joint1_position;
  pos_t joint2_position;
  pos_t joint3_position;
  pos_t joint4_position;
  pos_t joint5_position;
  pos_t joint6_position;
  logic move_done;
  logic command_rejected;

  modport source (output valid, joint0_position, joint1_position, joint2_position,
                  joint3_position, joint4_position, joint5_position, joint6_position,
                  move_done, command_rejected, input ready);
  modport sink   (input valid, joint0_position, joint1_position, joint2_position,
                  joint3_position, joint4_position, joint5_position, joint6_position,
                  move_done, command_rejected, output ready);
endinterface

// File: rtl/core/mjlr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module mjlr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mjlr_pkg::DIV_N-1:0] dividend_i,
  input  logic [mjlr_pkg::DIV_D-1:0] divisor_i,
  output logic                       busy_o,
  output logic [mjlr_pkg::DIV_N-1:0] quotient_o
);
  import mjlr_pkg::*;

  logic [DIV_D-1:0]     rem_q, rem_d;
  logic [DIV_N-1:0]     quo_q, quo_d;
  logic [DIV_D-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [DIV_D:0]       shifted;
  logic [DIV_D:0]       sub;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_N-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign sub     = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = DIV_CNT_W'(DIV_N - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? sub[DIV_D-1:0] : shifted[DIV_D-1:0];
      quo_d = {quo_q[DIV_N-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/mjlr_datapath.sv
// Datapath: joint positions, command table, step division, tick walk, output word.
module mjlr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mjlr_pkg::ctl_cmd_t            cmd_i,
  output mjlr_pkg::ctl_sts_t            sts_o,
  input  logic                          kind_i,
  input  logic [mjlr_pkg::JIDX_W-1:0]   joint_index_i,
  input  mjlr_pkg::pos_t                target_position_i,
  input  logic [mjlr_pkg::DUR_W-1:0]    duration_ms_i,
  input  logic [mjlr_pkg::TICK_W-1:0]   tick_period_i,
  input  logic [mjlr_pkg::MARGIN_W-1:0] arrive_margin_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output mjlr_pkg::pos_t                out_pos_o [mjlr_pkg::JOINTS],
  output logic                          out_done_o,
  output logic                          out_rejected_o
);
  import mjlr_pkg::*;

  // Latched input word and per-item flags
  kind_e             kind_q;
  logic [JIDX_W-1:0] joint_q;
  pos_t              target_q;
  logic [DUR_W-1:0]  dur_q;
  logic              rej_q;
  logic              done_q;
  logic              all_q;
  logic              neg_q;
  logic              short1_q;
  logic [CNT_W-1:0]  walk_q;

  // Architectural state
  pos_t              jp_q [JOINTS];
  logic [CNT_W-1:0]  count_q;
  logic [JIDX_W-1:0] ent_joint_q  [MAX_COMMANDS];
  pos_t              ent_target_q [MAX_COMMANDS];
  pos_t              ent_step_q   [MAX_COMMANDS];

  // Output register
  logic              out_valid_q;
  pos_t              out_pos_q [JOINTS];
  logic              out_done_q;
  logic              out_rej_q;

  // Divider hookup
  logic              div_start;
  logic [DIV_N-1:0]  div_dividend;
  logic [DIV_D-1:0]  div_divisor;
  logic              div_busy;
  logic [DIV_N-1:0]  div_quo;

  logic [TICK_W-1:0] per;
  logic [DIV_D-1:0]  ticks;
  logic [JIDX_W-1:0] csel;
  logic [POS_BITS:0] diff;
  logic [POS_BITS:0] mag;
  wide_t             step_wide;
  pos_t              step_new;

  logic [IDX_W-1:0]  eidx;
  logic [JIDX_W-1:0] ej;
  logic [JIDX_W-1:0] wj;
  pos_t              wpos;
  pos_t              wtarget;
  pos_t              wstep;
  logic              wshort;
  pos_t              wsum;

  logic              in_reject;

  // Step division setup
  assign per   = (tick_period_i == '0) ? TICK_W'(1) : tick_period_i;
  assign ticks = (div_quo[DIV_D-1:0] == '0) ? DIV_D'(1) : div_quo[DIV_D-1:0];
  assign csel  = ({1'b0, joint_q} < (JIDX_W+1)'(JOINTS)) ? joint_q : '0;
  assign diff  = {target_q[POS_BITS-1], target_q} - {jp_q[csel][POS_BITS-1], jp_q[csel]};
  assign mag   = diff[POS_BITS] ? (~diff + 1'b1) : diff;

  assign div_start    = cmd_i.div_ticks | cmd_i.div_step;
  assign div_dividend = cmd_i.div_step ? mag[POS_BITS-1:0] : DIV_N'(dur_q);
  assign div_divisor  = cmd_i.div_step ? ticks : DIV_D'(per);

  mjlr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Restore the sign of the quotient, then clamp
  always_comb begin
    step_wide = {2'b00, div_quo};
    if (neg_q) begin
      step_wide = -step_wide;
    end
    step_new = sat_pos(step_wide);
  end

  // Tick walk: one table entry at a time
  assign eidx    = walk_q[IDX_W-1:0];
  assign ej      = ent_joint_q[eidx];
  assign wj      = ({1'b0, ej} < (JIDX_W+1)'(JOINTS)) ? ej : '0;
  assign wpos    = jp_q[wj];
  assign wtarget = ent_target_q[eidx];
  assign wstep   = ent_step_q[eidx];
  assign wshort  = short_of(wpos, wtarget, wstep, arrive_margin_i);
  assign wsum    = sat_pos({{2{wpos[POS_BITS-1]}}, wpos} + {{2{wstep[POS_BITS-1]}}, wstep});

  assign in_reject = (kind_i == KIND_CMD) &&
                     ((count_q >= CNT_W'(MAX_COMMANDS)) ||
                      ({1'b0, joint_index_i} >= (JIDX_W+1)'(JOINTS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINTS; i++) begin
        jp_q[i] <= '0;
      end
      count_q     <= '0;
      walk_q      <= '0;
      all_q       <= 1'b1;
      done_q      <= 1'b0;
      rej_q       <= 1'b0;
      short1_q    <= 1'b0;
      neg_q       <= 1'b0;
      kind_q      <= KIND_CMD;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        kind_q <= kind_e'(kind_i);
        rej_q  <= in_reject;
        done_q <= 1'b0;
        all_q  <= 1'b1;
        walk_q <= '0;
      end
      if (cmd_i.div_step) begin
        neg_q <= diff[POS_BITS];
      end
      if (cmd_i.store) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.walk_a) begin
        short1_q <= wshort;
        if (wshort) begin
          jp_q[wj] <= wsum;
        end
      end
      if (cmd_i.walk_b) begin
        // jp_q now holds this entry's joint position, stepped if it was short of the target
        if (short1_q && wshort) begin
          all_q <= 1'b0;
        end
        walk_q <= walk_q + 1'b1;
      end
      if (cmd_i.finish) begin
        jp_q[JOINTS-1] <= jp_q[JOINTS-2];
        if (all_q) begin
          done_q  <= 1'b1;
          count_q <= '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      joint_q  <= joint_index_i;
      target_q <= target_position_i;
      dur_q    <= duration_ms_i;
    end
    if (cmd_i.store) begin
      ent_joint_q[count_q[IDX_W-1:0]]  <= joint_q;
      ent_target_q[count_q[IDX_W-1:0]] <= target_q;
      ent_step_q[count_q[IDX_W-1:0]]   <= step_new;
    end
    if (cmd_i.emit) begin
      out_pos_q  <= jp_q;
      out_done_q <= done_q;
      out_rej_q  <= rej_q;
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.reject    = rej_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.walk_more = walk_q < count_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_pos_o      = out_pos_q;
  assign out_done_o     = out_done_q;
  assign out_rejected_o = out_rej_q;

endmodule

// File: rtl/core/mjlr_ctrl.sv
// Controller: sequences command division, tick walk and result hand-off.
module mjlr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mjlr_pkg::ctl_sts_t sts_i,
  output mjlr_pkg::ctl_cmd_t cmd_o
);
  import mjlr_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.kind == KIND_TICK) begin
          state_d = ST_WALK_A;
        end else if (sts_i.reject) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_ticks = 1'b1;
          state_d         = ST_DIV_TICKS;
        end
      end
      ST_DIV_TICKS: begin
        // tick count ready: divide the distance by it
        if (!sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
          state_d        = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        if (!sts_i.div_busy) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_WALK_A: begin
        if (sts_i.walk_more) begin
          cmd_o.walk_a = 1'b1;
          state_d      = ST_WALK_B;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK_B: begin
        cmd_o.walk_b = 1'b1;
        state_d      = ST_WALK_A;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/multi_joint_linear_ramp.sv
// Top level of the multi-joint linear ramp: register port, controller, datapath.
//
//  Channel   Direction  Handshake               Word
//  in_i      sink       valid/ready             kind, joint_index, target, duration
//  out_o     source     valid/ready             seven joint positions, done, rejected
//  APB       slave      psel/penable/pready     tick_period_ms @0, arrive_margin @4
//
// A command runs two 24-step passes of the shared serial divider
// (ticks = duration / period, then step = distance / ticks) plus decode and store.
// A tick walks the table entry by entry, through WALK_A and WALK_B per entry, then FINISH.
// Reset clears positions, the table count and the registers to 30 ms and 655.
// A new word is taken while the previous result still waits in the output register;
// a stalled output holds the controller only when the next result is ready.
module multi_joint_linear_ramp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mjlr_in_if.sink                         in_i,
  mjlr_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mjlr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mjlr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mjlr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mjlr_pkg::*;

  logic [TICK_W-1:0]   tick_q;
  logic [MARGIN_W-1:0] margin_q;
  reg_idx_e            reg_idx;
  logic                reg_wr;

  ctl_cmd_t            cmd;
  ctl_sts_t            sts;
  pos_t                out_pos [JOINTS];

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= TICK_RESET;
      margin_q <= MARGIN_RESET;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_TICK_PERIOD:   tick_q   <= pwdata[TICK_W-1:0];
        REG_ARRIVE_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
        default:           tick_q   <= tick_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICK_PERIOD:   prdata = APB_DATA_W'(tick_q);
      REG_ARRIVE_MARGIN: prdata = APB_DATA_W'(margin_q);
      default:           prdata = '0;
    endcase
  end

  mjlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mjlr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (in_i.kind),
    .joint_index_i     (in_i.joint_index),
    .target_position_i (in_i.target_position),
    .duration_ms_i     (in_i.duration_ms),
    .tick_period_i     (tick_q),
    .arrive_margin_i   (margin_q),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_pos_o         (out_pos),
    .out_done_o        (out_o.move_done),
    .out_rejected_o    (out_o.command_rejected)
  );

  assign out_o.joint0_position = out_pos[0];
  assign out_o.joint1_position = out_pos[1];
  assign out_o.joint2_position = out_pos[2];
  assign out_o.joint3_position = out_pos[3];
  assign out_o.joint4_position = out_pos[4];
  assign out_o.joint5_position = out_pos[5];
  assign out_o.joint6_position = out_pos[6];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken again right after a word was accepted");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.move_done && out_o.command_rejected))
    else $error("done and rejected raised on the same result");

  a_gripper_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.joint6_position == out_o.joint5_position)
    else $error("right gripper does not follow left gripper");

endmodule
